// File: rtl/dqfa_pkg.sv
package dqfa_pkg;

  localparam int BUFFER_BYTES = 128;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int HDR_BYTES    = 12;
  localparam int TAIL_BYTES   = 16;
  localparam int TIDX_W       = $clog2(TAIL_BYTES);

  localparam logic [7:0] LIMIT_MAX = 8'(BUFFER_BYTES);

  // Configuration register indexes.
  localparam logic [1:0] REG_ANSWER_IPV4 = 2'd0;
  localparam logic [1:0] REG_MAX_QUERY   = 2'd1;
  localparam logic [1:0] REG_ANSWER_TTL  = 2'd2;

  localparam logic [7:0]  MAX_QUERY_RST = 8'd128;

  // Header byte positions with special handling.
  localparam logic [7:0] POS_FLAGS_HI = 8'd2;
  localparam logic [7:0] POS_FLAGS_LO = 8'd3;
  localparam logic [7:0] POS_QD_HI    = 8'd4;
  localparam logic [7:0] POS_QD_LO    = 8'd5;
  localparam logic [7:0] POS_AN_HI    = 8'd6;
  localparam logic [7:0] POS_AN_LO    = 8'd7;
  localparam logic [7:0] POS_ID_HI    = 8'd0;
  localparam logic [7:0] POS_ID_LO    = 8'd1;
  localparam logic [7:0] POS_HDR_END  = 8'(HDR_BYTES - 1);
  localparam logic [7:0] POS_SAT      = 8'hFF;

  localparam logic [7:0] FLAGS_QR_AA  = 8'h84;
  localparam logic [7:0] NAME_PTR_HI  = 8'hC0;
  localparam logic [7:0] NAME_PTR_LO  = 8'h0C;
  localparam logic [7:0] TYPE_A_LO    = 8'h01;
  localparam logic [7:0] CLASS_IN_LO  = 8'h01;
  localparam logic [7:0] RDLEN_LO     = 8'h04;
  localparam logic [7:0] ZERO_BYTE    = 8'h00;

  localparam logic [2:0] QTAIL_BYTES  = 3'd4;
  localparam logic [TIDX_W-1:0] TAIL_LAST_IDX = TIDX_W'(TAIL_BYTES - 1);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_QNAME  = 2'd1,
    PH_TAIL   = 2'd2,
    PH_DROP   = 2'd3
  } phase_t;

  // One entry of the queue between the parser and the output sequencer.
  typedef struct packed {
    logic       has_echo;
    logic [7:0] echo_byte;
    logic       last;
    logic       disc;
  } cmd_t;

  function automatic logic [7:0] tail_byte(input logic [TIDX_W-1:0] idx,
                                           input logic [31:0] ttl,
                                           input logic [31:0] ipv4);
    logic [7:0] b;
    case (idx)
      4'd0:    b = NAME_PTR_HI;
      4'd1:    b = NAME_PTR_LO;
      4'd2:    b = ZERO_BYTE;
      4'd3:    b = TYPE_A_LO;
      4'd4:    b = ZERO_BYTE;
      4'd5:    b = CLASS_IN_LO;
      4'd6:    b = ttl[31:24];
      4'd7:    b = ttl[23:16];
      4'd8:    b = ttl[15:8];
      4'd9:    b = ttl[7:0];
      4'd10:   b = ZERO_BYTE;
      4'd11:   b = RDLEN_LO;
      4'd12:   b = ipv4[31:24];
      4'd13:   b = ipv4[23:16];
      4'd14:   b = ipv4[15:8];
      4'd15:   b = ipv4[7:0];
      default: b = ZERO_BYTE;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/dqfa_in_if.sv
interface dqfa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// File: rtl/dqfa_out_if.sv
interface dqfa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       discard_frame;

  modport source (output valid, output out_byte, output out_last, output discard_frame,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input discard_frame,
                  output ready);
endinterface

// File: rtl/dqfa_front.sv
module dqfa_front (
  input  logic                clk,
  input  logic                rst_n,
  dqfa_in_if.sink             in_if,
  input  logic [7:0]          max_query,
  input  logic                q_full,
  output logic                q_push,
  output dqfa_pkg::cmd_t      q_cmd
);
  import dqfa_pkg::*;

  logic [7:0]  pos_r,      pos_nxt;
  phase_t      phase_r,    phase_nxt;
  logic [2:0]  tcnt_r,     tcnt_nxt;
  logic [15:0] qd_r,       qd_nxt;
  logic        too_long_r, too_long_nxt;

  logic [7:0]  limit;
  logic        accept;
  logic        too_long_v;
  logic        has_echo;
  logic [7:0]  echo;
  phase_t      phase_v;
  logic [2:0]  tcnt_v;
  logic [15:0] qd_v;
  logic [7:0]  tcnt_dec;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;
  assign limit       = (max_query < LIMIT_MAX) ? max_query : LIMIT_MAX;
  assign tcnt_dec    = {5'd0, tcnt_r} - 8'd1;

  always_comb begin
    too_long_v = too_long_r | (pos_r >= limit);
    has_echo   = 1'b0;
    echo       = ZERO_BYTE;
    phase_v    = phase_r;
    tcnt_v     = tcnt_r;
    qd_v       = qd_r;
    case (phase_r)
      PH_HEADER: begin
        has_echo = 1'b1;
        case (pos_r)
          POS_ID_HI, POS_ID_LO: echo = in_if.in_byte;
          POS_FLAGS_HI: echo = FLAGS_QR_AA | {7'd0, in_if.in_byte[0]};
          POS_FLAGS_LO: echo = ZERO_BYTE;
          POS_QD_HI: begin
            qd_v = {in_if.in_byte, qd_r[7:0]};
            echo = in_if.in_byte;
          end
          POS_QD_LO: begin
            qd_v = {qd_r[15:8], in_if.in_byte};
            echo = in_if.in_byte;
          end
          POS_AN_HI: echo = qd_r[15:8];
          POS_AN_LO: echo = qd_r[7:0];
          default:   echo = ZERO_BYTE;
        endcase
        if (pos_r >= POS_HDR_END) phase_v = PH_QNAME;
      end
      PH_QNAME: begin
        has_echo = 1'b1;
        echo     = in_if.in_byte;
        if (in_if.in_byte == ZERO_BYTE) begin
          phase_v = PH_TAIL;
          tcnt_v  = QTAIL_BYTES;
        end
      end
      PH_TAIL: begin
        has_echo = 1'b1;
        echo     = in_if.in_byte;
        tcnt_v   = tcnt_dec[2:0];
        if (tcnt_dec[2:0] == 3'd0) phase_v = PH_DROP;
      end
      default: has_echo = 1'b0;
    endcase
  end

  always_comb begin
    q_cmd.has_echo  = has_echo;
    q_cmd.echo_byte = echo;
    q_cmd.last      = in_if.in_last;
    q_cmd.disc      = too_long_v | (phase_v != PH_DROP);
    q_push          = accept && (has_echo || in_if.in_last);
  end

  always_comb begin
    pos_nxt      = pos_r;
    phase_nxt    = phase_r;
    tcnt_nxt     = tcnt_r;
    qd_nxt       = qd_r;
    too_long_nxt = too_long_r;
    if (accept) begin
      if (in_if.in_last) begin
        pos_nxt      = 8'd0;
        phase_nxt    = PH_HEADER;
        tcnt_nxt     = 3'd0;
        qd_nxt       = 16'd0;
        too_long_nxt = 1'b0;
      end else begin
        pos_nxt      = (pos_r == POS_SAT) ? pos_r : pos_r + 8'd1;
        phase_nxt    = phase_v;
        tcnt_nxt     = tcnt_v;
        qd_nxt       = qd_v;
        too_long_nxt = too_long_v;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= 8'd0;
      phase_r    <= PH_HEADER;
      tcnt_r     <= 3'd0;
      qd_r       <= 16'd0;
      too_long_r <= 1'b0;
    end else begin
      pos_r      <= pos_nxt;
      phase_r    <= phase_nxt;
      tcnt_r     <= tcnt_nxt;
      qd_r       <= qd_nxt;
      too_long_r <= too_long_nxt;
    end
  end

endmodule

// File: rtl/dqfa_queue.sv
module dqfa_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  dqfa_pkg::cmd_t push_cmd,
  input  logic           pop,
  output dqfa_pkg::cmd_t head_cmd,
  output logic           full,
  output logic           empty
);
  import dqfa_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push, do_pop;

  assign full     = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = mem_r[rd_r];

  always_comb begin
    wr_nxt  = do_push ? wr_r + QPTR_W'(1) : wr_r;
    rd_nxt  = do_pop  ? rd_r + QPTR_W'(1) : rd_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + QCNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/dqfa_back.sv
module dqfa_back (
  input  logic           clk,
  input  logic           rst_n,
  input  dqfa_pkg::cmd_t head_cmd,
  input  logic           q_empty,
  output logic           q_pop,
  input  logic [31:0]    answer_ttl,
  input  logic [31:0]    answer_ipv4,
  dqfa_out_if.source     out_if
);
  import dqfa_pkg::*;

  logic              ovalid_r, ovalid_nxt;
  logic [7:0]        obyte_r,  obyte_nxt;
  logic              olast_r,  olast_nxt;
  logic              odisc_r,  odisc_nxt;
  logic              tail_r,   tail_nxt;
  logic [TIDX_W-1:0] tidx_r,   tidx_nxt;
  logic              disc_r,   disc_nxt;
  logic              out_free;
  logic              tail_end;

  assign out_free = !ovalid_r || out_if.ready;
  assign tail_end = (tidx_r == TAIL_LAST_IDX);
  assign q_pop    = out_free && !tail_r && !q_empty;

  always_comb begin
    ovalid_nxt = ovalid_r;
    obyte_nxt  = obyte_r;
    olast_nxt  = olast_r;
    odisc_nxt  = odisc_r;
    tail_nxt   = tail_r;
    tidx_nxt   = tidx_r;
    disc_nxt   = disc_r;
    if (out_free) begin
      ovalid_nxt = 1'b0;
      if (tail_r) begin
        ovalid_nxt = 1'b1;
        obyte_nxt  = tail_byte(tidx_r, answer_ttl, answer_ipv4);
        olast_nxt  = tail_end;
        odisc_nxt  = tail_end & disc_r;
        tidx_nxt   = tidx_r + TIDX_W'(1);
        if (tail_end) tail_nxt = 1'b0;
      end else if (!q_empty) begin
        // A word with no echo byte is a frame end seen in the drop phase.
        ovalid_nxt = head_cmd.has_echo;
        obyte_nxt  = head_cmd.echo_byte;
        olast_nxt  = 1'b0;
        odisc_nxt  = 1'b0;
        if (head_cmd.last) begin
          tail_nxt = 1'b1;
          tidx_nxt = '0;
          disc_nxt = head_cmd.disc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    odisc_r <= odisc_nxt;
    tidx_r  <= tidx_nxt;
    disc_r  <= disc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      tail_r   <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      tail_r   <= tail_nxt;
    end
  end

  assign out_if.valid         = ovalid_r;
  assign out_if.out_byte      = obyte_r;
  assign out_if.out_last      = olast_r;
  assign out_if.discard_frame = odisc_r;

endmodule

// File: rtl/dns_query_to_fixed_answer.sv
// Channel   Direction  Payload                               Handshake
// in_if     sink       in_byte[7:0], in_last                 valid/ready
// out_if    source     out_byte[7:0], out_last, discard_frame valid/ready
// cfg_*     write      cfg_index[1:0], cfg_wdata[31:0]       cfg_we
//
// Query bytes are taken one per cycle while the queue has room; each echoed byte is
// written into the queue when it is accepted and then into the output register for out_if.
// The 16-byte answer record is played out by the output sequencer after the last
// byte, so input stalls once the four-word queue in front of it fills.
// Reset is synchronous; a downstream stall holds the output register and backs
// up through the queue to in_if.ready.
module dns_query_to_fixed_answer (
  input  logic        clk,
  input  logic        rst_n,
  dqfa_in_if.sink     in_if,
  dqfa_out_if.source  out_if,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);
  import dqfa_pkg::*;

  logic [31:0] ipv4_r, ipv4_nxt;
  logic [7:0]  maxq_r, maxq_nxt;
  logic [31:0] ttl_r,  ttl_nxt;

  cmd_t push_cmd, head_cmd;
  logic q_push, q_pop, q_full, q_empty;

  always_comb begin
    ipv4_nxt = ipv4_r;
    maxq_nxt = maxq_r;
    ttl_nxt  = ttl_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_ANSWER_IPV4: ipv4_nxt = cfg_wdata;
        REG_MAX_QUERY:   maxq_nxt = cfg_wdata[7:0];
        REG_ANSWER_TTL:  ttl_nxt  = cfg_wdata;
        default:         ipv4_nxt = ipv4_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ipv4_r <= 32'd0;
      maxq_r <= MAX_QUERY_RST;
      ttl_r  <= 32'd0;
    end else begin
      ipv4_r <= ipv4_nxt;
      maxq_r <= maxq_nxt;
      ttl_r  <= ttl_nxt;
    end
  end

  dqfa_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .max_query (maxq_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  dqfa_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  dqfa_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head_cmd    (head_cmd),
    .q_empty     (q_empty),
    .q_pop       (q_pop),
    .answer_ttl  (ttl_r),
    .answer_ipv4 (ipv4_r),
    .out_if      (out_if)
  );

endmodule

// File: tb/dns_query_to_fixed_answer_test.sv
`timescale 1ns / 100ps

module dns_query_to_fixed_answer_test;
  import dqfa_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int RANDOM_ITEMS  = 20;
  localparam int REPORT_LINES  = 60;

  // The port carries two index bits, so one index names no register.
  localparam logic [1:0] REG_NONE = 2'd3;

  typedef enum logic [1:0] {AT_HEADER, AT_QNAME, AT_QTAIL, AT_DROP} parse_at_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       disc;
  } resp_word_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_wdata;

  dqfa_in_if  query_if ();
  dqfa_out_if reply_if ();

  dns_query_to_fixed_answer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (query_if.sink),
    .out_if   (reply_if.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // Responder state as the block should hold it.
  logic [31:0] m_ipv4;
  logic [7:0]  m_max_query;
  logic [31:0] m_ttl;
  logic [7:0]  m_pos;
  parse_at_t   m_phase;
  logic [2:0]  m_qtail;
  logic [15:0] m_qdcount;
  logic        m_too_long;

  resp_word_t  response_due[$];
  logic [7:0]  frame_buf[$];
  int          mismatch_count = 0;
  int          cycle_count = 0;
  bit          quiet_in;
  bit          quiet_out;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("dns_query_to_fixed_answer regression: fail");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES)
      $display("%0t ns: %s is %0h, expected %0h", $time, what, got, want);
  endtask

  task automatic reset_frame_state();
    m_pos      = 8'd0;
    m_phase    = AT_HEADER;
    m_qtail    = 3'd0;
    m_qdcount  = 16'd0;
    m_too_long = 1'b0;
  endtask

  task automatic push_word(input logic [7:0] data, input logic last, input logic disc);
    resp_word_t w;
    w.data = data;
    w.last = last;
    w.disc = disc;
    response_due.push_back(w);
  endtask

  // Works out the response words that one accepted query byte causes.
  task automatic predict_response(input logic [7:0] b, input logic lst);
    logic [7:0] lim;
    logic [7:0] o;
    logic       disc;
    lim = (m_max_query < LIMIT_MAX) ? m_max_query : LIMIT_MAX;
    if (m_pos >= lim) m_too_long = 1'b1;
    case (m_phase)
      AT_HEADER: begin
        case (m_pos)
          8'd0, 8'd1: o = b;
          8'd2: o = 8'h84 | {7'd0, b[0]};
          8'd4: begin
            m_qdcount[15:8] = b;
            o = b;
          end
          8'd5: begin
            m_qdcount[7:0] = b;
            o = b;
          end
          8'd6: o = m_qdcount[15:8];
          8'd7: o = m_qdcount[7:0];
          default: o = 8'h00;
        endcase
        push_word(o, 1'b0, 1'b0);
        if (m_pos >= 8'd11) m_phase = AT_QNAME;
      end
      AT_QNAME: begin
        push_word(b, 1'b0, 1'b0);
        if (b == 8'h00) begin
          m_phase = AT_QTAIL;
          m_qtail = 3'd4;
        end
      end
      AT_QTAIL: begin
        push_word(b, 1'b0, 1'b0);
        m_qtail = m_qtail - 3'd1;
        if (m_qtail == 3'd0) m_phase = AT_DROP;
      end
      default: ;
    endcase
    if (m_pos != 8'hFF) m_pos = m_pos + 8'd1;
    if (lst) begin
      // A frame that ends before QCLASS is complete is dropped as well.
      disc = m_too_long | (m_phase != AT_DROP);
      push_word(8'hC0, 1'b0, 1'b0);
      push_word(8'h0C, 1'b0, 1'b0);
      push_word(8'h00, 1'b0, 1'b0);
      push_word(8'h01, 1'b0, 1'b0);
      push_word(8'h00, 1'b0, 1'b0);
      push_word(8'h01, 1'b0, 1'b0);
      push_word(m_ttl[31:24], 1'b0, 1'b0);
      push_word(m_ttl[23:16], 1'b0, 1'b0);
      push_word(m_ttl[15:8], 1'b0, 1'b0);
      push_word(m_ttl[7:0], 1'b0, 1'b0);
      push_word(8'h00, 1'b0, 1'b0);
      push_word(8'h04, 1'b0, 1'b0);
      push_word(m_ipv4[31:24], 1'b0, 1'b0);
      push_word(m_ipv4[23:16], 1'b0, 1'b0);
      push_word(m_ipv4[15:8], 1'b0, 1'b0);
      push_word(m_ipv4[7:0], 1'b1, disc);
      reset_frame_state();
    end
  endtask

  always @(posedge clk) begin
    resp_word_t due;
    if (rst_n && reply_if.valid && reply_if.ready) begin
      if (response_due.size() == 0) begin
        report_mismatch("word with nothing due, out_byte", reply_if.out_byte, 0);
      end else begin
        due = response_due.pop_front();
        if (reply_if.out_byte !== due.data)
          report_mismatch("out_byte", reply_if.out_byte, due.data);
        if (reply_if.out_last !== due.last)
          report_mismatch("out_last", reply_if.out_last, due.last);
        if (reply_if.discard_frame !== due.disc)
          report_mismatch("discard_frame", reply_if.discard_frame, due.disc);
      end
    end
  end

  // Response side: a random stall before each word unless told to stay quiet.
  initial begin
    int hold;
    reply_if.ready = 1'b0;
    @(negedge clk);
    forever begin
      hold = quiet_out ? 0 : $urandom_range(0, 17);
      if (hold != 0) begin
        reply_if.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      reply_if.ready <= 1'b1;
      do @(posedge clk); while (!(reply_if.valid && reply_if.ready));
      @(negedge clk);
    end
  end

  // Called and returning at a falling edge; valid is only touched at the start
  // and after the gap, so it never gets two assignments in one step.
  task automatic send_byte(input logic [7:0] b, input logic lst);
    int gap;
    gap = quiet_in ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      query_if.valid   <= 1'b0;
      query_if.in_byte <= 8'($urandom);
      query_if.in_last <= 1'($urandom);
      repeat (gap) @(negedge clk);
    end
    query_if.valid   <= 1'b1;
    query_if.in_byte <= b;
    query_if.in_last <= lst;
    do @(posedge clk); while (!query_if.ready);
    predict_response(b, lst);
    @(negedge clk);
  endtask

  task automatic send_frame(input int len);
    for (int i = 0; i < len; i++) send_byte(frame_buf[i], i == len - 1);
  endtask

  // Random header, a name of nonzero bytes and its zero byte, QTYPE/QCLASS,
  // then bytes past the question that the block must drop.
  task automatic build_query(input int name_len, input int extra_len);
    frame_buf.delete();
    repeat (12) frame_buf.push_back(8'($urandom));
    repeat (name_len) frame_buf.push_back(8'($urandom_range(1, 255)));
    frame_buf.push_back(8'h00);
    repeat (4 + extra_len) frame_buf.push_back(8'($urandom));
  endtask

  task automatic drain_results();
    query_if.valid <= 1'b0;
    do @(negedge clk); while (response_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_ANSWER_IPV4: m_ipv4 = val;
      REG_MAX_QUERY:   m_max_query = val[7:0];
      REG_ANSWER_TTL:  m_ttl = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_answer(input logic [31:0] ipv4, input logic [31:0] max_query,
                            input logic [31:0] ttl);
    drain_results();
    write_reg(REG_ANSWER_IPV4, ipv4);
    write_reg(REG_MAX_QUERY, max_query);
    write_reg(REG_ANSWER_TTL, ttl);
  endtask

  task automatic test_directed_cases();
    set_answer(32'hC0A8_0401, 32'd17, 32'h0000_012C);
    // A frame of one byte ends inside the header.
    frame_buf.delete();
    frame_buf.push_back(8'hFF);
    send_frame(1);
    // All ones in the header, root name, exactly at the length limit.
    frame_buf.delete();
    repeat (12) frame_buf.push_back(8'hFF);
    frame_buf.push_back(8'h00);
    repeat (4) frame_buf.push_back(8'hFF);
    send_frame(17);
    // All zeros in the header and two bytes over the limit.
    frame_buf.delete();
    repeat (12) frame_buf.push_back(8'h00);
    frame_buf.push_back(8'h80);
    frame_buf.push_back(8'h00);
    repeat (5) frame_buf.push_back(8'h00);
    send_frame(19);
  endtask

  task automatic test_register_settings();
    set_answer(32'h0000_0000, 32'd12, 32'h0000_0000);
    build_query(3, 0);
    send_frame(frame_buf.size());
    set_answer(32'hFFFF_FFFF, 32'd128, 32'hFFFF_FFFF);
    build_query(10, 2);
    send_frame(frame_buf.size());
    // Upper data bits must not reach the 8-bit limit register.
    set_answer(32'h8000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
    build_query(5, 1);
    send_frame(frame_buf.size());
    set_answer($urandom, {24'($urandom), 8'd20}, $urandom);
    write_reg(REG_NONE, $urandom);
    build_query(4, 3);
    send_frame(frame_buf.size());
  endtask

  task automatic test_pause_mid_frame();
    set_answer($urandom, 32'd128, $urandom);
    build_query(6, 2);
    for (int i = 0; i < frame_buf.size(); i++) begin
      send_byte(frame_buf[i], i == frame_buf.size() - 1);
      if (i == 14) drain_results();
    end
  endtask

  // The position counter stops at 255 in a frame far past the limit.
  task automatic test_position_saturation();
    set_answer($urandom, 32'd128, $urandom);
    quiet_in = 1'b1;
    build_query(20, 220);
    send_frame(frame_buf.size());
    quiet_in = 1'b0;
  endtask

  task automatic test_random_traffic();
    int phase_items;
    int kind;
    int len;
    for (int p = 0; p < 4; p++) begin
      case (p)
        0: set_answer($urandom, 32'd12, $urandom);
        1: set_answer($urandom, 32'd128, $urandom);
        2: set_answer($urandom, $urandom_range(12, 128), $urandom);
        default: set_answer($urandom, $urandom_range(17, 40), $urandom);
      endcase
      phase_items = 0;
      while (phase_items < RANDOM_ITEMS / 4) begin
        quiet_in  = ($urandom_range(0, 3) == 0);
        quiet_out = ($urandom_range(0, 3) == 0);
        kind = $urandom_range(0, 19);
        build_query(($urandom_range(0, 5) == 0) ? $urandom_range(0, 60)
                                                : $urandom_range(0, 12),
                    $urandom_range(0, 1) ? 0 : $urandom_range(1, 10));
        if (kind < 14) begin
          len = frame_buf.size();
        end else if (kind < 17) begin
          // Ends anywhere before the last byte of the built query.
          len = $urandom_range(1, frame_buf.size() - 1);
        end else begin
          len = $urandom_range(1, 30);
          frame_buf.delete();
          repeat (len) frame_buf.push_back(8'($urandom));
        end
        send_frame(len);
        phase_items += len;
      end
    end
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_ANSWER_IPV4;
    cfg_wdata        = 32'd0;
    query_if.valid   = 1'b0;
    query_if.in_byte = 8'd0;
    query_if.in_last = 1'b0;
    quiet_in         = 1'b0;
    quiet_out        = 1'b0;
    m_ipv4           = 32'd0;
    m_max_query      = MAX_QUERY_RST;
    m_ttl            = 32'd0;
    reset_frame_state();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed_cases();
    test_register_settings();
    test_pause_mid_frame();
    test_position_saturation();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0)
      $display("dns_query_to_fixed_answer regression: pass");
    else
      $display("dns_query_to_fixed_answer regression: fail");
    $finish;
  end

endmodule
